// ----- src/tokcm_pkg.sv -----
// Shared definitions for the character tokeniser: field widths, character
// constants, result class and error codes, register indexes and reset values.
// No dependencies.
package tokcm_pkg;

   // Field widths of the result word and the configuration port.
   localparam int CHAR_W     = 8;
   localparam int LEN_W      = 12;
   localparam int LINE_W     = 32;
   localparam int COL_W      = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int COUNT_W    = 4;
   localparam int MAX_SLOTS  = 8;

   // Default module parameters.
   localparam int SET_SLOTS_DEF      = 8;
   localparam int TOKEN_LEN_BITS_DEF = 12;

   // Line break characters.
   localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;

   // Register reset values: whitespace is space, FF, LF, CR, TAB and VT;
   // no comment start bytes; comments stop at LF or CR.
   localparam logic [CSR_DATA_W-1:0] SPACE_CHARS_RST = 64'h0000_0B09_0D0A_0C20;
   localparam logic [COUNT_W-1:0]    SPACE_COUNT_RST = 4'd6;
   localparam logic [CSR_DATA_W-1:0] OPEN_CHARS_RST  = 64'h0;
   localparam logic [COUNT_W-1:0]    OPEN_COUNT_RST  = 4'd0;
   localparam logic [CSR_DATA_W-1:0] CLOSE_CHARS_RST = 64'h0000_0000_0000_0D0A;
   localparam logic [COUNT_W-1:0]    CLOSE_COUNT_RST = 4'd2;
   localparam logic [LEN_W-1:0]      MAX_LEN_RST     = 12'd255;

   // Result class of a character.
   typedef enum logic [2:0] {
      CLS_SPACE = 3'd0,
      CLS_OPEN  = 3'd1,
      CLS_BODY  = 3'd2,
      CLS_CLOSE = 3'd3,
      CLS_TOKEN = 3'd4,
      CLS_END   = 3'd5
   } chr_class_type;

   // Error codes.
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_TOO_LONG = 2'd1,
      ERR_OPEN_END = 2'd2
   } err_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SPACE_CHARS = 3'd0,
      REG_SPACE_COUNT = 3'd1,
      REG_OPEN_CHARS  = 3'd2,
      REG_OPEN_COUNT  = 3'd3,
      REG_CLOSE_CHARS = 3'd4,
      REG_CLOSE_COUNT = 3'd5,
      REG_MAX_LEN     = 3'd6
   } csr_index_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [CSR_DATA_W-1:0] space_chars;
      logic [COUNT_W-1:0]    space_count;
      logic [CSR_DATA_W-1:0] open_chars;
      logic [COUNT_W-1:0]    open_count;
      logic [CSR_DATA_W-1:0] close_chars;
      logic [COUNT_W-1:0]    close_count;
      logic [LEN_W-1:0]      max_token_len;
   } cfg_type;

   // Set membership of the incoming character.
   typedef struct packed {
      logic space;
      logic open;
      logic close;
   } hit_type;

endpackage

// ----- src/tokcm_if.sv -----
// Valid/ready channels of the tokeniser: the character request channel and
// the classified result channel. Depends on tokcm_pkg.
interface tokcm_req_if;
   logic                         valid;
   logic                         ready;
   logic [tokcm_pkg::CHAR_W-1:0] char_in;
   logic                         end_of_input;

   modport source (output valid, output char_in, output end_of_input, input ready);
   modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface tokcm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tokcm_pkg::CHAR_W-1:0] char_out;
   logic [2:0]                   char_class;
   logic                         token_first;
   logic [tokcm_pkg::LEN_W-1:0]  token_length;
   logic [1:0]                   error_code;
   logic [tokcm_pkg::LINE_W-1:0] line_number;
   logic [tokcm_pkg::COL_W-1:0]  column_number;

   modport source (output valid, output char_out, output char_class, output token_first,
                   output token_length, output error_code, output line_number,
                   output column_number, input ready);
   modport sink   (input valid, input char_out, input char_class, input token_first,
                   input token_length, input error_code, input line_number,
                   input column_number, output ready);
endinterface

// ----- src/char_tokenizer_with_comments.sv -----
// Top level of the character tokeniser with comment handling.
// Depends on tokcm_pkg, tokcm_if, tokcm_csr, tokcm_match and tokcm_core.
//
// Usage:
//   req carries one character word (char_in, end_of_input) per handshake;
//   rsp returns exactly one classified word for each request word, in order.
//   The csr_ port writes the whitespace, comment start and comment stop sets,
//   their counts and the maximum token length; write only while idle.
// Throughput:
//   A word accepted at one edge appears on rsp right after that edge. One word
//   per cycle is sustained while rsp.ready is high: the set compares and state
//   update sit between the request and the single result register.
// Reset:
//   Synchronous reset restores the default character sets, line 1, column 0,
//   and clears comment, token and end-of-stream state.
// Stalls:
//   While rsp.ready is low a held result word stays and req.ready drops; it
//   rises again in the cycle the held word is taken, so no cycle is lost.
// After an end-of-input word every further word is answered as an end word
// until reset.
module char_tokenizer_with_comments #(
   parameter int SET_SLOTS      = tokcm_pkg::SET_SLOTS_DEF,
   parameter int TOKEN_LEN_BITS = tokcm_pkg::TOKEN_LEN_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   tokcm_req_if.sink                        req,
   tokcm_rsp_if.source                      rsp,
   input  logic                             csr_we,
   input  logic [tokcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tokcm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tokcm_pkg::cfg_type cfg;
   tokcm_pkg::hit_type hit;

   // Configuration registers.
   tokcm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Set membership of the incoming character.
   tokcm_match #(
      .SET_SLOTS (SET_SLOTS)
   ) u_match (
      .char_in (req.char_in),
      .cfg     (cfg),
      .hit     (hit)
   );

   // Classification, stream state and result register.
   tokcm_core #(
      .TOKEN_LEN_BITS (TOKEN_LEN_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .hit   (hit),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

// ----- src/tokcm_csr.sv -----
// Configuration register file of the tokeniser: seven write-only registers.
// Depends on tokcm_pkg.
module tokcm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tokcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tokcm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output tokcm_pkg::cfg_type               cfg
);

   tokcm_pkg::cfg_type cfg_ff;
   tokcm_pkg::cfg_type cfg_in;

   // Decode the write into the next register contents.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (tokcm_pkg::csr_index_type'(csr_index))
            tokcm_pkg::REG_SPACE_CHARS: cfg_in.space_chars = csr_wdata;
            tokcm_pkg::REG_SPACE_COUNT:
               cfg_in.space_count = csr_wdata[tokcm_pkg::COUNT_W-1:0];
            tokcm_pkg::REG_OPEN_CHARS: cfg_in.open_chars = csr_wdata;
            tokcm_pkg::REG_OPEN_COUNT:
               cfg_in.open_count = csr_wdata[tokcm_pkg::COUNT_W-1:0];
            tokcm_pkg::REG_CLOSE_CHARS: cfg_in.close_chars = csr_wdata;
            tokcm_pkg::REG_CLOSE_COUNT:
               cfg_in.close_count = csr_wdata[tokcm_pkg::COUNT_W-1:0];
            tokcm_pkg::REG_MAX_LEN:
               cfg_in.max_token_len = csr_wdata[tokcm_pkg::LEN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Registers load their documented defaults at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.space_chars   <= tokcm_pkg::SPACE_CHARS_RST;
         cfg_ff.space_count   <= tokcm_pkg::SPACE_COUNT_RST;
         cfg_ff.open_chars    <= tokcm_pkg::OPEN_CHARS_RST;
         cfg_ff.open_count    <= tokcm_pkg::OPEN_COUNT_RST;
         cfg_ff.close_chars   <= tokcm_pkg::CLOSE_CHARS_RST;
         cfg_ff.close_count   <= tokcm_pkg::CLOSE_COUNT_RST;
         cfg_ff.max_token_len <= tokcm_pkg::MAX_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/tokcm_match.sv -----
// Parallel set membership of one character against the whitespace, comment
// start and comment stop sets. Depends on tokcm_pkg.
module tokcm_match #(
   parameter int SET_SLOTS = tokcm_pkg::SET_SLOTS_DEF
) (
   input  logic [tokcm_pkg::CHAR_W-1:0] char_in,
   input  tokcm_pkg::cfg_type           cfg,
   output tokcm_pkg::hit_type           hit
);

   localparam int CharW  = tokcm_pkg::CHAR_W;
   localparam int CountW = tokcm_pkg::COUNT_W;

   // One compare per slot and set; a slot counts only below the set's count,
   // so a count at or above the number of slots behaves as a full set.
   always_comb begin
      hit = '0;
      for (int k = 0; k < SET_SLOTS; k++) begin
         if ((cfg.space_count > CountW'(k)) &&
             (cfg.space_chars[CharW*k +: CharW] == char_in))
            hit.space = 1'b1;
         if ((cfg.open_count > CountW'(k)) &&
             (cfg.open_chars[CharW*k +: CharW] == char_in))
            hit.open = 1'b1;
         if ((cfg.close_count > CountW'(k)) &&
             (cfg.close_chars[CharW*k +: CharW] == char_in))
            hit.close = 1'b1;
      end
   end

endmodule

// ----- src/tokcm_core.sv -----
// Tokeniser state and result register: classifies each accepted word, updates
// comment, token, line and column state, and holds the result word.
// Depends on tokcm_pkg and tokcm_if.
module tokcm_core #(
   parameter int TOKEN_LEN_BITS = tokcm_pkg::TOKEN_LEN_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tokcm_pkg::cfg_type   cfg,
   input  tokcm_pkg::hit_type   hit,
   tokcm_req_if.sink            req,
   tokcm_rsp_if.source          rsp
);

   localparam int LenW   = tokcm_pkg::LEN_W;
   localparam int LineW  = tokcm_pkg::LINE_W;
   localparam int ColW   = tokcm_pkg::COL_W;
   localparam int CharW  = tokcm_pkg::CHAR_W;
   localparam int CntW   = (TOKEN_LEN_BITS > LenW) ? LenW : TOKEN_LEN_BITS;
   localparam logic [CntW-1:0]  CntMax  = {CntW{1'b1}};
   localparam logic [LineW-1:0] LineMax = {LineW{1'b1}};
   localparam logic [ColW-1:0]  ColMax  = {ColW{1'b1}};

   // Stream state.
   logic             in_comment_ff, in_comment_in;
   logic             in_token_ff,   in_token_in;
   logic [CntW-1:0]  token_cnt_ff,  token_cnt_in;
   logic [LineW-1:0] line_ff,       line_in;
   logic [ColW-1:0]  col_ff,        col_in;
   logic             ended_ff,      ended_in;

   // Result register.
   logic                       rsp_valid_ff;
   logic [CharW-1:0]           char_ff,   char_in;
   tokcm_pkg::chr_class_type   cls_ff,    cls_in;
   logic                       first_ff,  first_in;
   logic [LenW-1:0]            len_ff,    len_in;
   tokcm_pkg::err_type         err_ff,    err_in;

   logic            accept;
   logic            is_break;
   logic [CntW-1:0] cnt_base;
   logic            cnt_at_max;
   logic [CntW-1:0] cnt_next;

   // A new word is taken whenever the result register is empty or draining.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Token length arithmetic: restart at zero on the first token character.
   assign is_break   = (req.char_in == tokcm_pkg::CHAR_LF) ||
                       (req.char_in == tokcm_pkg::CHAR_CR);
   assign cnt_base   = in_token_ff ? token_cnt_ff : '0;
   assign cnt_at_max = (cnt_base == CntMax);
   assign cnt_next   = cnt_at_max ? cnt_base : cnt_base + 1'b1;

   // Classification and next state for one word.
   always_comb begin
      in_comment_in = in_comment_ff;
      in_token_in   = in_token_ff;
      token_cnt_in  = token_cnt_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      ended_in      = ended_ff;
      char_in       = req.char_in;
      cls_in        = tokcm_pkg::CLS_TOKEN;
      first_in      = 1'b0;
      len_in        = '0;
      err_in        = tokcm_pkg::ERR_NONE;

      if (req.end_of_input || ended_ff) begin
         // End of stream, and every word after it until reset.
         ended_in = 1'b1;
         char_in  = '0;
         cls_in   = tokcm_pkg::CLS_END;
         err_in   = in_comment_ff ? tokcm_pkg::ERR_OPEN_END : tokcm_pkg::ERR_NONE;
      end else begin
         // Line and column, reported after the update.
         if (is_break) begin
            if (line_ff != LineMax)
               line_in = line_ff + 1'b1;
            col_in = '0;
         end else if (col_ff != ColMax) begin
            col_in = col_ff + 1'b1;
         end

         if (in_comment_ff) begin
            cls_in       = hit.close ? tokcm_pkg::CLS_CLOSE : tokcm_pkg::CLS_BODY;
            in_comment_in = !hit.close;
            in_token_in  = 1'b0;
            token_cnt_in = '0;
         end else if (hit.space) begin
            cls_in       = tokcm_pkg::CLS_SPACE;
            in_token_in  = 1'b0;
            token_cnt_in = '0;
         end else if (hit.open) begin
            cls_in        = tokcm_pkg::CLS_OPEN;
            in_comment_in = 1'b1;
            in_token_in   = 1'b0;
            token_cnt_in  = '0;
         end else begin
            cls_in       = tokcm_pkg::CLS_TOKEN;
            first_in     = !in_token_ff;
            in_token_in  = 1'b1;
            token_cnt_in = cnt_next;
            len_in       = LenW'(cnt_next);
            if (cnt_at_max || (LenW'(cnt_next) > cfg.max_token_len))
               err_in = tokcm_pkg::ERR_TOO_LONG;
         end
      end
   end

   // State registers advance on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff <= 1'b0;
         in_token_ff   <= 1'b0;
         token_cnt_ff  <= '0;
         line_ff       <= LineW'(1);
         col_ff        <= '0;
         ended_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            in_comment_ff <= in_comment_in;
            in_token_ff   <= in_token_in;
            token_cnt_ff  <= token_cnt_in;
            line_ff       <= line_in;
            col_ff        <= col_in;
            ended_ff      <= ended_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // Result payload loads with the word; it needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff  <= char_in;
         cls_ff   <= cls_in;
         first_ff <= first_in;
         len_ff   <= len_in;
         err_ff   <= err_in;
      end
   end

   // Line and column of a result are the state after its word.
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.char_out      = char_ff;
   assign rsp.char_class    = cls_ff;
   assign rsp.token_first   = first_ff;
   assign rsp.token_length  = len_ff;
   assign rsp.error_code    = err_ff;
   assign rsp.line_number   = line_ff;
   assign rsp.column_number = col_ff;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for char_tokenizer_with_comments: drives character words,
// predicts each classified word in step with the stream and compares field by field.
// Depends on tokcm_pkg, tokcm_if and the tokeniser RTL.
`timescale 1ns / 1ps

module tb_top;
   import tokcm_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TOK_SAT     = ((1 << TOKEN_LEN_BITS_DEF) - 1) < 4095 ?
                                ((1 << TOKEN_LEN_BITS_DEF) - 1) : 4095;
   localparam int PHASE_WORDS = 90;

   // One predicted result word.
   typedef struct {
      logic [CHAR_W-1:0] chr;
      chr_class_type     cls;
      logic              first;
      logic [LEN_W-1:0]  len;
      err_type           err;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  col;
   } tok_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tokcm_req_if req_bus ();
   tokcm_rsp_if rsp_bus ();

   char_tokenizer_with_comments dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Tokeniser state and register copy kept by the testbench.
   cfg_type           tk_cfg;
   logic              tk_in_comment;
   logic              tk_in_token;
   logic [LEN_W-1:0]  tk_tok;
   logic [LINE_W-1:0] tk_line;
   logic [COL_W-1:0]  tk_col;
   logic              tk_ended;

   tok_word_type expected_words[$];
   int        mismatches  = 0;
   int        sent_words  = 0;
   int        cycles      = 0;
   bit        idle_on     = 1'b0;
   int        rx_hold     = 0;
   int        rx_burst    = 0;

   always #6 clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic bit byte_hit(logic [63:0] set, logic [3:0] cnt, logic [7:0] c);
      int n;
      n = (cnt > SET_SLOTS_DEF) ? SET_SLOTS_DEF : cnt;
      for (int k = 0; k < n; k++)
         if (set[8*k +: 8] == c) return 1'b1;
      return 1'b0;
   endfunction

   // Works out the result word for one accepted character word and advances
   // the tokeniser state.
   function automatic tok_word_type classify_char(logic [7:0] c, logic eoi);
      tok_word_type r;
      r.chr   = c;
      r.first = 1'b0;
      r.len   = '0;
      r.err   = ERR_NONE;
      if (eoi || tk_ended) begin
         tk_ended = 1'b1;
         r.chr  = '0;
         r.cls  = CLS_END;
         r.err  = tk_in_comment ? ERR_OPEN_END : ERR_NONE;
         r.line = tk_line;
         r.col  = tk_col;
         return r;
      end
      // Line breaks move to the next line, anything else to the next column.
      if (c == CHAR_LF || c == CHAR_CR) begin
         if (tk_line != 32'hFFFF_FFFF) tk_line++;
         tk_col = '0;
      end else if (tk_col != 16'hFFFF) begin
         tk_col++;
      end
      if (tk_in_comment) begin
         if (byte_hit(tk_cfg.close_chars, tk_cfg.close_count, c)) begin
            r.cls = CLS_CLOSE;
            tk_in_comment = 1'b0;
         end else begin
            r.cls = CLS_BODY;
         end
         tk_in_token = 1'b0;
         tk_tok      = '0;
      end else if (byte_hit(tk_cfg.space_chars, tk_cfg.space_count, c)) begin
         r.cls       = CLS_SPACE;
         tk_in_token = 1'b0;
         tk_tok      = '0;
      end else if (byte_hit(tk_cfg.open_chars, tk_cfg.open_count, c)) begin
         r.cls         = CLS_OPEN;
         tk_in_comment = 1'b1;
         tk_in_token   = 1'b0;
         tk_tok        = '0;
      end else begin
         r.cls = CLS_TOKEN;
         if (!tk_in_token) begin
            r.first     = 1'b1;
            tk_in_token = 1'b1;
            tk_tok      = '0;
         end
         // The counter saturates; past the limit every character is an overflow.
         if (tk_tok >= TOK_SAT) begin
            r.err = ERR_TOO_LONG;
         end else begin
            tk_tok++;
            if (tk_tok > tk_cfg.max_token_len) r.err = ERR_TOO_LONG;
         end
         r.len = tk_tok;
      end
      r.line = tk_line;
      r.col  = tk_col;
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned exp, longint unsigned got);
      if (exp != got) begin
         $error("%s: expected %0d, got %0d", name, exp, got);
         mismatches++;
      end
   endtask

   // Compare every result word taken with the oldest prediction.
   always @(posedge clock) begin
      tok_word_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word: char_out %0d, class %0d",
                   rsp_bus.char_out, rsp_bus.char_class);
            mismatches++;
         end else begin
            exp = expected_words.pop_front();
            check_field("char_out", exp.chr, rsp_bus.char_out);
            check_field("char_class", exp.cls, rsp_bus.char_class);
            check_field("token_first", exp.first, rsp_bus.token_first);
            check_field("token_length", exp.len, rsp_bus.token_length);
            check_field("error_code", exp.err, rsp_bus.error_code);
            check_field("line_number", exp.line, rsp_bus.line_number);
            check_field("column_number", exp.col, rsp_bus.column_number);
         end
      end
   end

   // Result side: long hold-offs on request, otherwise random stall bursts.
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rx_hold--;
      end else if (rx_burst > 0) begin
         rsp_bus.ready <= 1'b0;
         rx_burst--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         rx_burst = $urandom_range(0, 17);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Offers one character word, waits for it to be taken and predicts its result.
   task automatic send_char(logic [7:0] c, logic eoi = 1'b0);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.char_in      <= c;
      req_bus.end_of_input <= eoi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_words.push_back(classify_char(c, eoi));
      sent_words++;
   endtask

   // Stops offering words and waits until every predicted result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Register write; only called while the tokeniser is idle.
   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_SPACE_CHARS: tk_cfg.space_chars   = val;
         REG_SPACE_COUNT: tk_cfg.space_count   = val[COUNT_W-1:0];
         REG_OPEN_CHARS:  tk_cfg.open_chars    = val;
         REG_OPEN_COUNT:  tk_cfg.open_count    = val[COUNT_W-1:0];
         REG_CLOSE_CHARS: tk_cfg.close_chars   = val;
         REG_CLOSE_COUNT: tk_cfg.close_count   = val[COUNT_W-1:0];
         REG_MAX_LEN:     tk_cfg.max_token_len = val[LEN_W-1:0];
         default: ;
      endcase
   endtask

   // Random fill above the meaningful bits of a narrow register.
   function automatic logic [63:0] with_junk(logic [63:0] val, int bits);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      return (junk << bits) | val;
   endfunction

   // Picks one member of a character set, or any byte when the set is empty.
   function automatic logic [7:0] pick_byte(logic [63:0] set, logic [3:0] cnt);
      int n;
      n = (cnt > SET_SLOTS_DEF) ? SET_SLOTS_DEF : cnt;
      if (n == 0) return 8'($urandom_range(0, 255));
      return set[8*$urandom_range(0, n-1) +: 8];
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   // Default sets: words, whitespace of every kind and both line breaks.
   task automatic test_default_stream();
      logic [7:0] text[] = '{8'h61, 8'h62, 8'h20, 8'h63, 8'h09, CHAR_LF,
                             8'h78, CHAR_CR, 8'h0B, 8'h0C, 8'h00, 8'hFF};
      foreach (text[i]) send_char(text[i]);
      drain_results();
   endtask

   // Comment sets, overlap of whitespace and start bytes, a count above the
   // number of slots, short and zero token limits, empty sets.
   task automatic test_comment_sets();
      logic [7:0] text[] = '{8'h61, 8'h62, 8'h63, 8'h20, 8'h23, 8'h78, 8'h20,
                             8'h21, 8'h21, 8'h40, CHAR_LF, 8'h3B, CHAR_CR, CHAR_LF};
      write_reg(REG_SPACE_CHARS, 64'h0000_0000_0000_0920);
      write_reg(REG_SPACE_COUNT, 64'hFFFF_FFFF_FFFF_FFF2);
      write_reg(REG_OPEN_CHARS,  64'h4023_2323_2320_3B23);
      write_reg(REG_OPEN_COUNT,  64'h0000_0000_0000_000F);
      write_reg(REG_CLOSE_CHARS, 64'h0000_0000_0000_0A21);
      write_reg(REG_CLOSE_COUNT, 64'hFFFF_FFFF_FFFF_FFF2);
      write_reg(REG_MAX_LEN,     64'hFFFF_FFFF_FFFF_F002);
      foreach (text[i]) send_char(text[i]);
      drain_results();
      // With a limit of zero every token character overflows.
      write_reg(REG_MAX_LEN, 64'h0);
      send_char(8'h71);
      drain_results();
      // An empty whitespace set lets the space open a comment.
      write_reg(REG_SPACE_COUNT, 64'h0);
      send_char(8'h20);
      send_char(8'h6B);
      send_char(8'h21);
      drain_results();
      write_reg(REG_OPEN_COUNT, 64'h0);
      send_char(8'h23);
      drain_results();
   endtask

   // One long token runs well past the length limit, so every character
   // after the limit is flagged.
   task automatic test_saturation();
      write_reg(REG_SPACE_CHARS, SPACE_CHARS_RST);
      write_reg(REG_SPACE_COUNT, 64'(SPACE_COUNT_RST));
      write_reg(REG_MAX_LEN, 64'd120);
      send_char(CHAR_LF);
      repeat (160) send_char(rand_letter());
      send_char(CHAR_CR);
      send_char(rand_letter());
      drain_results();
   endtask

   // A long stall on the result side backs up the input, then the sender
   // pauses until everything has come out.
   task automatic test_backpressure();
      idle_on = 1'b1;
      send_char(rand_letter());
      rx_hold = 300;
      repeat (40) send_char($urandom_range(0, 3) == 0 ? 8'h20 : rand_letter());
      drain_results();
      repeat (40) send_char($urandom_range(0, 3) == 0 ? CHAR_LF : rand_letter());
      drain_results();
   endtask

   // One well-formed piece of text, or a stray byte now and then.
   task automatic send_sequence();
      int kind;
      int n;
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
         repeat (n) send_char(rand_letter());
      end else if (kind < 12) begin
         send_char(pick_byte(tk_cfg.space_chars, tk_cfg.space_count));
      end else if (kind < 14) begin
         send_char($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
      end else if (kind < 18) begin
         send_char(pick_byte(tk_cfg.open_chars, tk_cfg.open_count));
         n = $urandom_range(0, 6);
         repeat (n) send_char($urandom_range(0, 1) ? rand_letter() : 8'h20);
         send_char(pick_byte(tk_cfg.close_chars, tk_cfg.close_count));
      end else begin
         send_char(8'($urandom_range(0, 255)));
      end
   endtask

   // Register settings of one random phase.
   task automatic load_phase_config(int ph);
      case (ph)
         0: begin
            write_reg(REG_SPACE_CHARS, SPACE_CHARS_RST);
            write_reg(REG_SPACE_COUNT, 64'(SPACE_COUNT_RST));
            write_reg(REG_OPEN_CHARS, 64'h23);
            write_reg(REG_OPEN_COUNT, 64'd1);
            write_reg(REG_CLOSE_CHARS, CLOSE_CHARS_RST);
            write_reg(REG_CLOSE_COUNT, 64'(CLOSE_COUNT_RST));
            write_reg(REG_MAX_LEN, 64'($urandom_range(2, 8)));
         end
         1: begin
            write_reg(REG_SPACE_CHARS, {$urandom, $urandom});
            write_reg(REG_SPACE_COUNT, with_junk($urandom_range(0, 15), COUNT_W));
            write_reg(REG_OPEN_CHARS, {$urandom, $urandom});
            write_reg(REG_OPEN_COUNT, with_junk($urandom_range(0, 15), COUNT_W));
            write_reg(REG_CLOSE_CHARS, {$urandom, $urandom});
            write_reg(REG_CLOSE_COUNT, with_junk($urandom_range(0, 15), COUNT_W));
            write_reg(REG_MAX_LEN, with_junk(0, LEN_W));
         end
         2: begin
            // Nothing but tokens, with the loosest limit.
            write_reg(REG_SPACE_COUNT, 64'd0);
            write_reg(REG_OPEN_COUNT, 64'd0);
            write_reg(REG_CLOSE_CHARS, {$urandom, $urandom});
            write_reg(REG_CLOSE_COUNT, 64'd8);
            write_reg(REG_MAX_LEN, with_junk(4095, LEN_W));
         end
         3: begin
            write_reg(REG_SPACE_CHARS, {$urandom, $urandom});
            write_reg(REG_SPACE_COUNT, 64'd8);
            write_reg(REG_OPEN_CHARS, {$urandom, $urandom});
            write_reg(REG_OPEN_COUNT, 64'd8);
            write_reg(REG_CLOSE_CHARS, {$urandom, $urandom});
            write_reg(REG_CLOSE_COUNT, 64'd8);
            write_reg(REG_MAX_LEN, 64'($urandom_range(1, 20)));
         end
         default: begin
            write_reg(REG_SPACE_CHARS, 64'h20);
            write_reg(REG_SPACE_COUNT, 64'd1);
            write_reg(REG_OPEN_CHARS, {$urandom, $urandom});
            write_reg(REG_OPEN_COUNT, 64'd15);
            write_reg(REG_CLOSE_CHARS, {$urandom, $urandom});
            write_reg(REG_CLOSE_COUNT, 64'd15);
            write_reg(REG_MAX_LEN, with_junk($urandom_range(0, 4095), LEN_W));
         end
      endcase
   endtask

   // Random text over several register settings; one phase runs without idling.
   task automatic test_random_text();
      int stop_at;
      for (int ph = 0; ph < 5; ph++) begin
         load_phase_config(ph);
         idle_on = (ph != 2);
         stop_at = sent_words + PHASE_WORDS;
         while (sent_words < stop_at) send_sequence();
         drain_results();
      end
   endtask

   // End of stream, possibly inside an open comment; every later word is an
   // end word whatever it carries.
   task automatic test_end_of_stream();
      idle_on = 1'b0;
      write_reg(REG_SPACE_CHARS, SPACE_CHARS_RST);
      write_reg(REG_SPACE_COUNT, 64'(SPACE_COUNT_RST));
      write_reg(REG_OPEN_CHARS, 64'h23);
      write_reg(REG_OPEN_COUNT, 64'd1);
      write_reg(REG_CLOSE_CHARS, CLOSE_CHARS_RST);
      write_reg(REG_CLOSE_COUNT, 64'(CLOSE_COUNT_RST));
      send_char(8'h61);
      if ($urandom_range(0, 1)) begin
         send_char(8'h23);
         send_char(8'h7A);
      end
      send_char(8'h55, 1'b1);
      send_char(8'h62);
      send_char(8'hFF, 1'b1);
      send_char(8'h00);
      drain_results();
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.char_in      = '0;
      req_bus.end_of_input = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_we               = 1'b0;
      csr_index            = REG_SPACE_CHARS;
      csr_wdata            = '0;
      // State after reset.
      tk_cfg.space_chars   = SPACE_CHARS_RST;
      tk_cfg.space_count   = SPACE_COUNT_RST;
      tk_cfg.open_chars    = OPEN_CHARS_RST;
      tk_cfg.open_count    = OPEN_COUNT_RST;
      tk_cfg.close_chars   = CLOSE_CHARS_RST;
      tk_cfg.close_count   = CLOSE_COUNT_RST;
      tk_cfg.max_token_len = MAX_LEN_RST;
      tk_in_comment        = 1'b0;
      tk_in_token          = 1'b0;
      tk_tok               = '0;
      tk_line              = 32'd1;
      tk_col               = '0;
      tk_ended             = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_stream();
      test_comment_sets();
      test_saturation();
      test_backpressure();
      test_random_text();
      test_end_of_stream();

      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
